// ===== rtl/rscpb_pkg.sv =====
// ----------------------------------------------------------------------------
// rscpb_pkg
// Shared types and constants of the run-length sprite cel blitter.
// ----------------------------------------------------------------------------
package rscpb_pkg;

   localparam int CODE_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int RUN_W       = 4;
   localparam int PRIO_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int PIX_ADDR_W  = 15;
   localparam int COL_W       = 11;
   localparam int COORD_W     = 12;
   localparam int DIM_W       = 8;
   localparam int ORIGIN_W    = 10;

   localparam logic [PRIO_W-1:0]       PRIO_FREE = 4'd4;
   localparam logic signed [COL_W-1:0] COL_MIN   = -11'sd1024;
   localparam logic signed [COL_W-1:0] COL_MAX   = 11'sd1023;

   localparam logic [DIM_W-1:0] CEL_WIDTH_RESET  = 8'd1;
   localparam logic [DIM_W-1:0] CEL_HEIGHT_RESET = 8'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CEL_WIDTH         = 3'd0,
      REG_CEL_HEIGHT        = 3'd1,
      REG_MIRROR_ENABLE     = 3'd2,
      REG_TRANSPARENT_COLOR = 3'd3,
      REG_ORIGIN_X          = 3'd4,
      REG_ORIGIN_Y          = 3'd5,
      REG_VIEW_PRIORITY     = 3'd6
   } csr_index_type;

   // one pixel handed from the run sequencer to the write-back stage
   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pix_type;

endpackage

// ===== rtl/rscpb_prio_store.sv =====
// ----------------------------------------------------------------------------
// rscpb_prio_store
// Priority store: registered synchronous read, one write port, write-first
// forwarding, and a clearing pass to the free priority after reset.
// ----------------------------------------------------------------------------
module rscpb_prio_store
   import rscpb_pkg::*;
#(
   parameter int DEPTH  = 26880,
   parameter int ADDR_W = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [PRIO_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [PRIO_W-1:0] wr_data,
   output logic              clear_busy
);

   logic [PRIO_W-1:0] prio_mem_ff [DEPTH];
   logic [PRIO_W-1:0] rd_data_ff;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [PRIO_W-1:0] mem_wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   assign mem_we    = clearing_ff || wr_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? PRIO_FREE : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prio_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   // a read of the entry written in the same cycle sees the new value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (mem_we && (mem_waddr == rd_addr)) begin
            rd_data_ff <= mem_wdata;
         end else begin
            rd_data_ff <= prio_mem_ff[rd_addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

   a_clear_ends_at_top: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(clr_addr_ff) == ADDR_W'(DEPTH - 1))
      else $error("clearing pass ended early");

   a_no_read_while_clearing: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !clearing_ff)
      else $error("priority read during clearing pass");

endmodule

// ===== rtl/rscpb_run_seq.sv =====
// ----------------------------------------------------------------------------
// rscpb_run_seq
// Configuration registers, cel row and column tracking, and the run
// sequencer that steps one pixel per cycle while advance is high and issues store reads.
// ----------------------------------------------------------------------------
module rscpb_run_seq
   import rscpb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 168,
   parameter int ADDR_W        = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   input  logic [CODE_W-1:0]      req_code_byte,
   output logic                   req_stall,
   input  logic                   clear_busy,
   input  logic                   advance,
   output pix_type                pix,
   output logic [ADDR_W-1:0]      pix_addr,
   output logic [PRIO_W-1:0]      view_priority
);

   localparam int PROD_W = COORD_W + $clog2(SCREEN_WIDTH + 1);
   localparam logic signed [COORD_W-1:0] SCR_W_C = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] SCR_H_C = COORD_W'(SCREEN_HEIGHT);

   logic [DIM_W-1:0]           cel_width_ff, cel_width_in;
   logic [DIM_W-1:0]           cel_height_ff, cel_height_in;
   logic                       mirror_ff, mirror_in;
   logic [COLOR_W-1:0]         transp_ff, transp_in;
   logic signed [ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic signed [ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [PRIO_W-1:0]          view_prio_ff, view_prio_in;

   logic signed [COL_W-1:0]    column_ff, column_in;
   logic [DIM_W-1:0]           row_ff, row_in;
   logic signed [COORD_W-1:0]  py_ff, py_in;
   logic [ADDR_W-1:0]          row_base_ff;
   logic                       busy_ff, busy_in;
   logic [RUN_W-1:0]           cnt_ff, cnt_in;
   logic [COLOR_W-1:0]         color_ff, color_in;

   logic                       cfg_hit;
   logic                       step, accept, row_ok, py_ok, px_ok, nxt_ok;
   logic signed [COL_W-1:0]    col_step;
   logic signed [COORD_W-1:0]  px, px_nxt;
   logic [PROD_W-1:0]          base_prod;

   function automatic logic signed [COL_W-1:0] reload_col(input logic mirror,
                                                          input logic [DIM_W-1:0] width);
      logic signed [COL_W-1:0] wide;
      wide = $signed({{(COL_W - DIM_W){1'b0}}, width});
      return mirror ? wide - 11'sd1 : '0;
   endfunction

   // register decode
   always_comb begin
      cel_width_in  = cel_width_ff;
      cel_height_in = cel_height_ff;
      mirror_in     = mirror_ff;
      transp_in     = transp_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      view_prio_in  = view_prio_ff;
      cfg_hit       = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_CEL_WIDTH: begin
               cel_width_in = csr_wr_data[DIM_W-1:0];
               cfg_hit      = 1'b1;
            end
            REG_CEL_HEIGHT: begin
               cel_height_in = csr_wr_data[DIM_W-1:0];
               cfg_hit       = 1'b1;
            end
            REG_MIRROR_ENABLE: begin
               mirror_in = csr_wr_data[0];
               cfg_hit   = 1'b1;
            end
            REG_TRANSPARENT_COLOR: begin
               transp_in = csr_wr_data[COLOR_W-1:0];
               cfg_hit   = 1'b1;
            end
            REG_ORIGIN_X: begin
               origin_x_in = $signed(csr_wr_data[ORIGIN_W-1:0]);
               cfg_hit     = 1'b1;
            end
            REG_ORIGIN_Y: begin
               origin_y_in = $signed(csr_wr_data[ORIGIN_W-1:0]);
               cfg_hit     = 1'b1;
            end
            REG_VIEW_PRIORITY: begin
               view_prio_in = csr_wr_data[PRIO_W-1:0];
               cfg_hit      = 1'b1;
            end
            default: cfg_hit = 1'b0;
         endcase
      end
   end

   // pixel position and clipping
   always_comb begin
      if (mirror_ff) begin
         col_step = (column_ff != COL_MIN) ? column_ff - 11'sd1 : column_ff;
      end else begin
         col_step = (column_ff != COL_MAX) ? column_ff + 11'sd1 : column_ff;
      end
   end

   assign px     = COORD_W'(origin_x_ff) + COORD_W'(column_ff);
   assign px_nxt = COORD_W'(origin_x_ff) + COORD_W'(col_step);
   assign px_ok  = (px >= 0) && (px < SCR_W_C);
   // the column moves monotonically, so once past the far edge the run stays off
   assign nxt_ok = (px_nxt >= 0) && (px_nxt < SCR_W_C);
   assign py_ok  = (py_ff >= 0) && (py_ff < SCR_H_C);
   assign row_ok = row_ff < cel_height_ff;

   assign step      = busy_ff && advance;
   assign req_stall = clear_busy || (busy_ff && !(step && (cnt_ff == RUN_W'(1))));
   assign accept    = req_valid && !req_stall;

   assign pix.valid = step && (color_ff != transp_ff) && px_ok && py_ok;
   assign pix.color = color_ff;
   assign pix.last  = (cnt_ff == RUN_W'(1)) || !nxt_ok;
   assign pix_addr  = row_base_ff + ADDR_W'($unsigned(px));

   assign view_priority = view_prio_ff;
   assign base_prod     = PROD_W'(py_ff) * PROD_W'(SCREEN_WIDTH);

   // cel walk
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      py_in     = py_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      color_in  = color_ff;
      if (step) begin
         column_in = col_step;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == RUN_W'(1)) begin
            busy_in = 1'b0;
         end
      end
      if (accept && row_ok) begin
         if (req_code_byte == '0) begin
            row_in    = row_ff + 1'b1;
            py_in     = py_ff + 12'sd1;
            column_in = reload_col(mirror_ff, cel_width_ff);
         end else if (req_code_byte[RUN_W-1:0] != '0) begin
            busy_in  = 1'b1;
            cnt_in   = req_code_byte[RUN_W-1:0];
            color_in = req_code_byte[CODE_W-1:RUN_W];
         end
      end
      if (cfg_hit) begin
         row_in    = '0;
         column_in = reload_col(mirror_in, cel_width_in);
         py_in     = COORD_W'(origin_y_in) - $signed({4'b0000, cel_height_in}) + 12'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cel_width_ff  <= CEL_WIDTH_RESET;
         cel_height_ff <= CEL_HEIGHT_RESET;
         mirror_ff     <= 1'b0;
         transp_ff     <= '0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         view_prio_ff  <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
         py_ff         <= '0;
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         cel_width_ff  <= cel_width_in;
         cel_height_ff <= cel_height_in;
         mirror_ff     <= mirror_in;
         transp_ff     <= transp_in;
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         view_prio_ff  <= view_prio_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         py_ff         <= py_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
      end
   end

   // row base is registered from the screen row of the previous cycle; no run steps before it catches up
   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      row_base_ff <= base_prod[ADDR_W-1:0];
   end

   a_busy_has_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("run sequencer busy with zero count");

   a_hold_column: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !advance && !csr_wr_en |=> $stable(column_ff))
      else $error("column moved while write-back stage was full");

endmodule

// ===== rtl/rle_sprite_cel_priority_blitter.sv =====
// ----------------------------------------------------------------------------
// rle_sprite_cel_priority_blitter
// Run-length sprite cel blitter with a priority store.
//
// The req_ channel takes one code word per handshake: zero ends the row,
// otherwise the high nibble is the color and the low nibble the run length.
// The rsp_ channel gives one display write word per visible pixel, with
// run_last on the final write caused by a code word. Registers are written
// through csr_wr_en / csr_index / csr_wr_data; the user must write them only
// while the block is idle, which the block itself does not enforce; every
// write to a defined register restarts the cel. A run keeps the sequencer
// busy until its last pixel steps, and the next code word can be taken as
// that pixel steps; one pixel a cycle, while the write-back stage has room,
// is the rate of the priority read-modify-write through the store's read and
// write ports. After reset a clearing pass sets all SCREEN_WIDTH*SCREEN_HEIGHT
// priority entries to the free value, with req_stall high. When rsp_stall
// holds the output register, the write-back stage keeps its pixel; once that
// stage is full the sequencer pauses and, while a run is in progress,
// req_stall rises.
// ----------------------------------------------------------------------------
module rle_sprite_cel_priority_blitter
   import rscpb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 160,
   parameter int SCREEN_HEIGHT = 168
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CODE_W-1:0]      req_code_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_ADDR_W-1:0]  rsp_pixel_address,
   output logic [COLOR_W-1:0]     rsp_pixel_color,
   output logic                   rsp_priority_updated,
   output logic                   rsp_run_last
);

   localparam int STORE_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   pix_type             pix;
   logic [ADDR_W-1:0]   pix_addr;
   logic [PRIO_W-1:0]   view_priority;
   logic [PRIO_W-1:0]   rd_data;
   logic                clear_busy;
   logic                out_free, advance, s2_move, upd, wr_en;

   logic                s2_valid_ff, s2_valid_in;
   logic [ADDR_W-1:0]   s2_addr_ff;
   logic [COLOR_W-1:0]  s2_color_ff;
   logic                s2_last_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_ADDR_W-1:0] rsp_addr_ff;
   logic [COLOR_W-1:0]  rsp_color_ff;
   logic                rsp_upd_ff;
   logic                rsp_last_ff;

   rscpb_run_seq #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .ADDR_W        (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_code_byte (req_code_byte),
      .req_stall     (req_stall),
      .clear_busy    (clear_busy),
      .advance       (advance),
      .pix           (pix),
      .pix_addr      (pix_addr),
      .view_priority (view_priority)
   );

   rscpb_prio_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (pix.valid),
      .rd_addr    (pix_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (s2_addr_ff),
      .wr_data    (view_priority),
      .clear_busy (clear_busy)
   );

   // write-back stage: priority compare and update, then the output register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = !s2_valid_ff || out_free;
   assign s2_move  = s2_valid_ff && out_free;
   assign upd      = rd_data >= PRIO_FREE;
   assign wr_en    = s2_move && upd;

   always_comb begin
      s2_valid_in  = advance ? pix.valid : s2_valid_ff;
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix.valid) begin
         s2_addr_ff  <= pix_addr;
         s2_color_ff <= pix.color;
         s2_last_ff  <= pix.last;
      end
      if (s2_move) begin
         rsp_addr_ff  <= PIX_ADDR_W'(s2_addr_ff);
         rsp_color_ff <= s2_color_ff;
         rsp_upd_ff   <= upd;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pixel_address    = rsp_addr_ff;
   assign rsp_pixel_color      = rsp_color_ff;
   assign rsp_priority_updated = rsp_upd_ff;
   assign rsp_run_last         = rsp_last_ff;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_addr_ff))
      else $error("write-back stage lost its pixel under stall");

   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      pix.valid |=> s2_valid_ff)
      else $error("issued priority read not captured by write-back stage");

endmodule
